@@ rtl/nfha_pkg.sv @@
`default_nettype none
package nfha_pkg;

  localparam int DEF_HEAP_BYTES = 65536;
  localparam int WORD_BYTES     = 4;
  localparam int DSIZE          = 8;
  localparam int MIN_BLOCK      = 2 * DSIZE;
  localparam int CHUNK_RESET    = 1 << 12;
  localparam int LIST_START     = 8;

  localparam int REQ_W   = 16;
  localparam int ADDR_W  = 16;
  localparam int GRANT_W = 17;
  localparam int CHUNK_W = 17;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

endpackage
`default_nettype wire

@@ rtl/nfha_if.sv @@
`default_nettype none
interface nfha_req_if;
  import nfha_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [REQ_W-1:0]    request_bytes;
  logic [ADDR_W-1:0]   block_addr;
  modport source (output valid, action, request_bytes, block_addr, input ready);
  modport sink (input valid, action, request_bytes, block_addr, output ready);
endinterface

interface nfha_rsp_if;
  import nfha_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [ADDR_W-1:0]   result_addr;
  logic [GRANT_W-1:0]  granted_bytes;
  modport source (output valid, status, result_addr, granted_bytes, input ready);
  modport sink (input valid, status, result_addr, granted_bytes, output ready);
endinterface
`default_nettype wire

@@ rtl/next_fit_heap_allocator_unit.sv @@
`default_nettype none
// Next-fit boundary-tag heap allocator. The tags live in one single-port-read,
// single-port-write memory of HEAP_BYTES/4 words, and each step of the work reads
// or writes at most one tag word a cycle. After reset a clearing pass writes the
// initial heap image, one word a cycle, while no request is taken. An allocate
// searches from the rover, then from the list start; a miss grows the heap if it
// has room, merging the new space with a free block before it. A free clears the
// allocated bits in the block's tags and merges it with free neighbours. A new
// request is taken only once the last one is done. How long an allocate takes
// depends on the search walk through the block list, and so on fragmentation.
module next_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES = nfha_pkg::DEF_HEAP_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  nfha_req_if.sink                         req,
  nfha_rsp_if.source                       rsp,
  input  wire logic                        cfg_wr_en,
  input  wire logic [nfha_pkg::CHUNK_W-1:0] cfg_wr_data
);
  import nfha_pkg::*;

  localparam int AW    = $clog2(HEAP_BYTES);
  localparam int IW    = AW - 2;
  localparam int TW    = AW + 2;
  localparam int EW    = (TW > 18) ? TW : 18;
  localparam int SW    = ((AW + 1) > 18 ? (AW + 1) : 18) + 1;
  localparam int DEPTH = HEAP_BYTES / WORD_BYTES;
  localparam int LIMIT = HEAP_BYTES / 8 + 1;
  localparam int KW    = $clog2(LIMIT + 1);
  localparam bit INIT_FIT = (2 * DSIZE + CHUNK_RESET) <= HEAP_BYTES;
  localparam int FTR_W = (DSIZE + CHUNK_RESET) / WORD_BYTES;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_F_RD  = 5'd2;
  localparam logic [4:0] S_F_CLR = 5'd3;
  localparam logic [4:0] S_WQ    = 5'd4;
  localparam logic [4:0] S_M0    = 5'd5;
  localparam logic [4:0] S_M1    = 5'd6;
  localparam logic [4:0] S_M2    = 5'd7;
  localparam logic [4:0] S_M3    = 5'd8;
  localparam logic [4:0] S_M4    = 5'd9;
  localparam logic [4:0] S_M5    = 5'd10;
  localparam logic [4:0] S_M6    = 5'd11;
  localparam logic [4:0] S_SRCH  = 5'd12;
  localparam logic [4:0] S_L1    = 5'd13;
  localparam logic [4:0] S_L2_ST = 5'd14;
  localparam logic [4:0] S_L2    = 5'd15;
  localparam logic [4:0] S_MISS  = 5'd16;
  localparam logic [4:0] S_P_RD  = 5'd17;
  localparam logic [4:0] S_PLC   = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  function automatic logic [TW-1:0] init_tag(input logic [IW-1:0] w);
    logic [TW-1:0] v;
    v = '0;
    if (w == IW'(1) || w == IW'(2)) begin
      v = TW'(DSIZE + 1);
    end else if (w == IW'(3)) begin
      v = INIT_FIT ? TW'(CHUNK_RESET) : TW'(1);
    end else if (INIT_FIT && w == IW'(FTR_W)) begin
      v = TW'(CHUNK_RESET);
    end else if (INIT_FIT && w == IW'(FTR_W + 1)) begin
      v = TW'(1);
    end
    return v;
  endfunction

  logic [TW-1:0] mem [DEPTH];
  logic [TW-1:0] rd_data;
  logic          mem_we;
  logic [IW-1:0] mem_widx;
  logic [TW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [4:0]         state;
  logic [IW-1:0]      clr_idx;
  logic [AW-1:0]      rover;
  logic [AW:0]        heap_break;
  logic [CHUNK_W-1:0] chunk;
  logic [AW-1:0]      bp;
  logic [AW-1:0]      p;
  logic [AW-1:0]      n;
  logic [AW-1:0]      nf;
  logic [TW-1:0]      psize;
  logic [TW-1:0]      bsize;
  logic [TW-1:0]      nsize;
  logic               palloc;
  logic               nalloc;
  logic               from_grow;
  logic [16:0]        asize;
  logic [KW-1:0]      k;
  logic [AW-1:0]      wq_addr [4];
  logic [TW-1:0]      wq_data [4];
  logic [1:0]         wq_idx;
  logic [1:0]         wq_last;
  logic [4:0]         wq_ret;
  logic [1:0]         res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [GRANT_W-1:0] res_granted;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [ADDR_W-1:0]  out_addr;
  logic [GRANT_W-1:0] out_granted;

  logic [TW-1:0] rd_sz;
  logic [AW-1:0] rd_sa;
  logic [AW-1:0] p_c;
  logic [AW-1:0] nxt;
  logic          fits;
  logic          last_k;
  logic          l1_go;
  logic          l2_go;
  logic [TW-1:0] sum_bn;
  logic [TW-1:0] sum_bp;
  logic [TW-1:0] sum_all;
  logic [EW-1:0] diff_e;
  logic [TW-1:0] diff_t;
  logic          split;
  logic [AW-1:0] asz_a;
  logic [16:0]   ext;
  logic [15:0]   ewords;
  logic [17:0]   ew;
  logic [SW-1:0] hb_sum;
  logic [16:0]   a_round;

  assign rd_sz   = {rd_data[TW-1:3], 3'b000};
  assign rd_sa   = rd_sz[AW-1:0];
  assign p_c     = bp - rd_sa;
  assign nxt     = bp + rd_sa;
  assign fits    = !rd_data[0] && (EW'(asize) <= EW'(rd_sz));
  assign last_k  = (k == KW'(LIMIT - 1));
  assign l1_go   = (rd_sz != '0) && !fits && !last_k;
  assign l2_go   = !fits && !last_k && (nxt != rover);
  assign sum_bn  = bsize + nsize;
  assign sum_bp  = bsize + psize;
  assign sum_all = sum_bp + rd_sz;
  assign diff_e  = EW'(rd_sz) - EW'(asize);
  assign diff_t  = diff_e[TW-1:0];
  assign split   = (EW'(rd_sz) < EW'(asize)) || (diff_e >= EW'(MIN_BLOCK));
  assign asz_a   = AW'(asize);
  assign ext     = (asize > chunk) ? asize : chunk;
  assign ewords  = 16'(ext[16:2]) + 16'(ext[2]);
  assign ew      = {ewords, 2'b00};
  assign hb_sum  = SW'(heap_break) + SW'(ew);
  assign a_round = 17'(req.request_bytes) + 17'(2 * DSIZE - 1);

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.result_addr   = out_addr;
  assign rsp.granted_bytes = out_granted;

  always_comb begin
    mem_we    = 1'b0;
    mem_widx  = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_widx  = clr_idx;
        mem_wdata = init_tag(clr_idx);
      end
      S_WQ: begin
        mem_we    = 1'b1;
        mem_widx  = wq_addr[wq_idx][AW-1:2];
        mem_wdata = wq_data[wq_idx];
      end
      S_F_RD, S_M3, S_P_RD: begin
        mem_re    = 1'b1;
        mem_raddr = bp - AW'(4);
      end
      S_M0: begin
        mem_re    = 1'b1;
        mem_raddr = bp - AW'(DSIZE);
      end
      S_M1: begin
        mem_re    = 1'b1;
        mem_raddr = p_c - AW'(4);
      end
      S_M2: begin
        mem_re    = 1'b1;
        mem_raddr = p + rd_sa - AW'(DSIZE);
      end
      S_M4: begin
        mem_re    = 1'b1;
        mem_raddr = nxt - AW'(4);
      end
      S_M5: begin
        mem_re    = 1'b1;
        mem_raddr = n + rd_sa - AW'(DSIZE);
      end
      S_SRCH: begin
        mem_re    = 1'b1;
        mem_raddr = rover - AW'(4);
      end
      S_L1: begin
        mem_re    = l1_go;
        mem_raddr = nxt - AW'(4);
      end
      S_L2_ST: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(LIST_START - 4);
      end
      S_L2: begin
        mem_re    = l2_go;
        mem_raddr = nxt - AW'(4);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr[AW-1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      rover      <= INIT_FIT ? AW'(2 * DSIZE) : AW'(LIST_START);
      heap_break <= INIT_FIT ? (AW + 1)'(2 * DSIZE + CHUNK_RESET) : (AW + 1)'(2 * DSIZE);
      chunk      <= CHUNK_W'(CHUNK_RESET);
      out_valid  <= 1'b0;
      wq_idx     <= '0;
      wq_last    <= '0;
      wq_ret     <= S_IDLE;
      from_grow  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chunk <= cfg_wr_data;
      end
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            res_addr    <= '0;
            res_granted <= '0;
            if (req.action == ACT_FREE) begin
              res_status <= ST_DONE;
              bp         <= AW'(req.block_addr);
              state      <= S_F_RD;
            end else if (req.request_bytes == '0) begin
              res_status <= ST_ZERO;
              state      <= S_DONE;
            end else begin
              res_status <= ST_DONE;
              asize <= (req.request_bytes <= 16'(DSIZE)) ? 17'(MIN_BLOCK)
                                                         : {a_round[16:3], 3'b000};
              state <= S_SRCH;
            end
          end
        end
        S_F_RD: begin
          state <= S_F_CLR;
        end
        S_F_CLR: begin
          wq_addr[0] <= bp - AW'(4);
          wq_data[0] <= rd_sz;
          wq_addr[1] <= bp + rd_sa - AW'(DSIZE);
          wq_data[1] <= rd_sz;
          wq_idx     <= '0;
          wq_last    <= 2'd1;
          wq_ret     <= S_M0;
          from_grow  <= 1'b0;
          state      <= S_WQ;
        end
        S_WQ: begin
          wq_idx <= wq_idx + 2'd1;
          if (wq_idx == wq_last) begin
            state <= wq_ret;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          p     <= p_c;
          state <= S_M2;
        end
        S_M2: begin
          psize <= rd_sz;
          state <= S_M3;
        end
        S_M3: begin
          palloc <= rd_data[0];
          state  <= S_M4;
        end
        S_M4: begin
          bsize <= rd_sz;
          n     <= nxt;
          state <= S_M5;
        end
        S_M5: begin
          nalloc <= rd_data[0];
          nsize  <= rd_sz;
          nf     <= n + rd_sa - AW'(DSIZE);
          state  <= S_M6;
        end
        S_M6: begin
          wq_idx  <= '0;
          wq_last <= 2'd1;
          wq_ret  <= from_grow ? S_P_RD : S_DONE;
          if (palloc && nalloc) begin
            rover <= bp;
            state <= from_grow ? S_P_RD : S_DONE;
          end else begin
            state <= S_WQ;
            if (palloc) begin
              wq_addr[0] <= bp - AW'(4);
              wq_data[0] <= sum_bn;
              wq_addr[1] <= bp + sum_bn[AW-1:0] - AW'(DSIZE);
              wq_data[1] <= sum_bn;
              rover      <= bp;
            end else if (nalloc) begin
              wq_addr[0] <= bp + bsize[AW-1:0] - AW'(DSIZE);
              wq_data[0] <= sum_bp;
              wq_addr[1] <= p - AW'(4);
              wq_data[1] <= sum_bp;
              rover      <= p;
              bp         <= p;
            end else begin
              wq_addr[0] <= p - AW'(4);
              wq_data[0] <= sum_all;
              wq_addr[1] <= nf;
              wq_data[1] <= sum_all;
              rover      <= p;
              bp         <= p;
            end
          end
        end
        S_SRCH: begin
          bp    <= rover;
          k     <= '0;
          state <= S_L1;
        end
        S_L1: begin
          if (rd_sz == '0) begin
            state <= S_L2_ST;
          end else if (fits) begin
            state <= S_P_RD;
          end else if (last_k) begin
            state <= S_L2_ST;
          end else begin
            bp <= nxt;
            k  <= k + KW'(1);
          end
        end
        S_L2_ST: begin
          bp    <= AW'(LIST_START);
          k     <= '0;
          state <= (rover == AW'(LIST_START)) ? S_MISS : S_L2;
        end
        S_L2: begin
          if (fits) begin
            state <= S_P_RD;
          end else if (!l2_go) begin
            state <= S_MISS;
          end else begin
            bp <= nxt;
            k  <= k + KW'(1);
          end
        end
        S_MISS: begin
          if (hb_sum > SW'(HEAP_BYTES)) begin
            res_status <= ST_OOM;
            state      <= S_DONE;
          end else begin
            bp         <= heap_break[AW-1:0];
            heap_break <= hb_sum[AW:0];
            wq_addr[0] <= heap_break[AW-1:0] - AW'(4);
            wq_data[0] <= TW'(ew);
            wq_addr[1] <= heap_break[AW-1:0] + AW'(ew) - AW'(DSIZE);
            wq_data[1] <= TW'(ew);
            wq_addr[2] <= heap_break[AW-1:0] + AW'(ew) - AW'(4);
            wq_data[2] <= TW'(1);
            wq_idx     <= '0;
            wq_last    <= 2'd2;
            wq_ret     <= S_M0;
            from_grow  <= 1'b1;
            state      <= S_WQ;
          end
        end
        S_P_RD: begin
          state <= S_PLC;
        end
        S_PLC: begin
          wq_idx     <= '0;
          wq_ret     <= S_DONE;
          res_status <= ST_DONE;
          res_addr   <= ADDR_W'(bp);
          state      <= S_WQ;
          if (split) begin
            wq_addr[0]  <= bp - AW'(4);
            wq_data[0]  <= TW'(asize) | TW'(1);
            wq_addr[1]  <= bp + asz_a - AW'(DSIZE);
            wq_data[1]  <= TW'(asize) | TW'(1);
            wq_addr[2]  <= bp + asz_a - AW'(4);
            wq_data[2]  <= diff_t;
            wq_addr[3]  <= bp + asz_a + diff_t[AW-1:0] - AW'(DSIZE);
            wq_data[3]  <= diff_t;
            wq_last     <= 2'd3;
            res_granted <= GRANT_W'({asize[16:3], 3'b000} & 17'(TW'(asize)));
          end else begin
            wq_addr[0]  <= bp - AW'(4);
            wq_data[0]  <= rd_sz | TW'(1);
            wq_addr[1]  <= bp + rd_sa - AW'(DSIZE);
            wq_data[1]  <= rd_sz | TW'(1);
            wq_last     <= 2'd1;
            res_granted <= GRANT_W'(rd_sz);
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_addr    <= res_addr;
            out_granted <= res_granted;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/nfha_checker.sv @@
`default_nettype none
module nfha_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic [1:0]                   status,
  input wire logic [nfha_pkg::ADDR_W-1:0]  result_addr,
  input wire logic [nfha_pkg::GRANT_W-1:0] granted_bytes
);
  import nfha_pkg::*;

  a_rst_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(result_addr)
                                && $stable(granted_bytes))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_DONE |-> result_addr == '0 && granted_bytes == '0)
    else $error("failed request carries a block");

  a_grant_align: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> granted_bytes[2:0] == 3'b000)
    else $error("granted size not a multiple of eight");

endmodule

bind next_fit_heap_allocator_unit nfha_checker u_nfha_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .result_addr   (rsp.result_addr),
  .granted_bytes (rsp.granted_bytes)
);
`default_nettype wire
